>>> hw/rtl/multi_finger_tap_recognizer_defines.svh
// Assertion macros for the tap recognizer
`ifndef MULTI_FINGER_TAP_RECOGNIZER_DEFINES_SVH
`define MULTI_FINGER_TAP_RECOGNIZER_DEFINES_SVH
`ifndef SYNTH
`define MFTR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MFTR_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MFTR_ASSERT(label, clk, rst, prop, msg)
`define MFTR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/mftr_pkg.sv
`default_nettype none
package mftr_pkg;
  localparam int MaxFingers = 16;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int CoordW = 16;

  localparam logic [0:0] REG_MOVE_LIMIT = 1'b0;
  localparam logic [0:0] REG_TAP_GAP    = 1'b1;

  typedef enum logic [1:0] {
    REQ_DOWN = 2'd0, REQ_UP = 2'd1, REQ_MOVE = 2'd2, REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_DOWN = 2'd1, ACT_UP = 2'd2, ACT_MOVE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    GST_NONE = 2'd0, GST_TAP = 2'd1, GST_PRE = 2'd2
  } gst_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SEARCH, ST_DIST, ST_UPCOPY, ST_COMPACT, ST_FINISH, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic search_step;
    logic measure;
    logic copy_step;
    logic compact_step;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    req_t kind;
    logic scan_done;
    logic found;
    logic emit_last;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/mftr_ctrl.sv
`default_nettype none
module mftr_ctrl
  import mftr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        unique case (sts.kind)
          REQ_MOVE: state_next = ST_SEARCH;
          REQ_UP: state_next = ST_UPCOPY;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SEARCH: begin
        if (sts.found) state_next = ST_DIST;
        else if (sts.scan_done) state_next = ST_FINISH;
        else cmd.search_step = 1'b1;
      end
      ST_DIST: begin
        cmd.measure = 1'b1;
        state_next = ST_FINISH;
      end
      ST_UPCOPY: begin
        if (sts.scan_done) state_next = ST_COMPACT;
        else cmd.copy_step = 1'b1;
      end
      ST_COMPACT: begin
        if (sts.scan_done) state_next = ST_FINISH;
        else cmd.compact_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/mftr_datapath.sv
`default_nettype none
module mftr_datapath
  import mftr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic [135:0] in_data,
  input  wire cmd_t         cmd,
  output sts_t              sts,
  input  wire logic         out_ready,
  output logic              out_valid,
  output logic [151:0]      out_data,
  output logic              out_last
);
  logic [31:0] limit_sq;
  logic [15:0] gap_ms;

  logic [1:0]  r_kind;
  logic [31:0] r_id;
  logic signed [CoordW-1:0] r_x, r_y, r_dx, r_dy;
  logic [31:0] r_time;

  logic [CntW-1:0] finger_total;
  logic [31:0] ident [MaxFingers];
  logic signed [CoordW-1:0] now_x [MaxFingers];
  logic signed [CoordW-1:0] now_y [MaxFingers];
  logic signed [CoordW-1:0] st_x [MaxFingers];
  logic signed [CoordW-1:0] st_y [MaxFingers];
  logic signed [CoordW-1:0] spot_x [MaxFingers];
  logic signed [CoordW-1:0] spot_y [MaxFingers];
  logic [7:0] tap_number;
  logic [CntW-1:0] tap_finger_total, spot_total;
  logic tap_spoiled, lifting;
  logic [31:0] prev_time;

  logic [CntW-1:0] scan, wr;
  logic found;
  logic [IdxW-1:0] hit;
  logic [1:0] gesture;
  logic [7:0] taps;
  logic [CntW-1:0] n_out, emit_i;
  logic signed [CoordW:0] ddx, ddy;
  logic [33:0] sqx, sqy;
  logic dist_phase;

  logic [IdxW-1:0] sidx;
  assign sidx = scan[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_sq <= 32'd400;
      gap_ms <= 16'd500;
    end else if (cfg_we) begin
      if (cfg_index == REG_MOVE_LIMIT) limit_sq <= cfg_data;
      else gap_ms <= cfg_data[15:0];
    end
  end

  assign sts.kind = req_t'(r_kind);
  assign sts.scan_done = (scan >= finger_total) && !dist_phase;
  assign sts.found = found;
  assign sts.emit_last = (emit_i + 5'd1 == n_out);
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_total <= '0;
      tap_number <= '0;
      tap_finger_total <= '0;
      spot_total <= '0;
      tap_spoiled <= 1'b0;
      lifting <= 1'b0;
      prev_time <= '0;
      out_valid <= 1'b0;
      found <= 1'b0;
      dist_phase <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        r_kind <= in_data[1:0];
        r_id <= in_data[33:2];
        r_x <= in_data[49:34];
        r_y <= in_data[65:50];
        r_dx <= in_data[81:66];
        r_dy <= in_data[97:82];
        r_time <= in_data[129:98];
        scan <= '0;
        wr <= '0;
        found <= 1'b0;
        emit_i <= '0;
        gesture <= GST_NONE;
        taps <= '0;
      end
      if (cmd.decode) begin
        if (r_kind == REQ_DOWN) begin
          if (lifting) begin
            tap_number <= '0; tap_finger_total <= '0; spot_total <= '0;
            tap_spoiled <= 1'b1;
          end else if ((r_time - prev_time) > {16'd0, gap_ms}) begin
            tap_number <= '0; tap_finger_total <= '0; spot_total <= '0;
          end
          if (finger_total < CntW'(MaxFingers)) begin
            ident[finger_total[IdxW-1:0]] <= r_id;
            now_x[finger_total[IdxW-1:0]] <= r_x;
            now_y[finger_total[IdxW-1:0]] <= r_y;
            st_x[finger_total[IdxW-1:0]] <= r_x;
            st_y[finger_total[IdxW-1:0]] <= r_y;
            finger_total <= finger_total + 5'd1;
          end
        end else if (r_kind == REQ_UP && !lifting) begin
          if (finger_total != tap_finger_total) begin
            tap_number <= '0;
            tap_finger_total <= finger_total;
          end
          spot_total <= finger_total;
        end
      end
      if (cmd.search_step) begin
        if (ident[sidx] == r_id) begin
          found <= 1'b1;
          hit <= sidx;
          ddx <= (CoordW+1)'(r_x) - (CoordW+1)'(st_x[sidx]);
          ddy <= (CoordW+1)'(r_y) - (CoordW+1)'(st_y[sidx]);
          dist_phase <= 1'b1;
        end
        scan <= scan + 5'd1;
      end
      if (found && dist_phase && !cmd.measure) begin
        sqx <= 34'(ddx * ddx);
        sqy <= 34'(ddy * ddy);
        dist_phase <= 1'b0;
      end
      if (cmd.measure) begin
        now_x[hit] <= r_x;
        now_y[hit] <= r_y;
        if ((35'(sqx) + 35'(sqy)) > 35'(limit_sq)) begin
          tap_number <= '0; tap_finger_total <= '0; spot_total <= '0;
          tap_spoiled <= 1'b1;
        end
      end
      if (cmd.copy_step) begin
        if (!lifting) begin
          spot_x[sidx] <= now_x[sidx];
          spot_y[sidx] <= now_y[sidx];
        end
        scan <= scan + 5'd1;
      end
      if (cmd.compact_step) begin
        if (ident[sidx] != r_id) begin
          ident[wr[IdxW-1:0]] <= ident[sidx];
          now_x[wr[IdxW-1:0]] <= now_x[sidx];
          now_y[wr[IdxW-1:0]] <= now_y[sidx];
          st_x[wr[IdxW-1:0]] <= st_x[sidx];
          st_y[wr[IdxW-1:0]] <= st_y[sidx];
          wr <= wr + 5'd1;
        end
        scan <= scan + 5'd1;
      end
      if (r_kind == REQ_UP && cmd.copy_step == 1'b0 && scan >= finger_total
          && !cmd.compact_step && !cmd.load && !cmd.decode && !cmd.finish
          && !cmd.emit && scan != '0 && wr != scan) begin
        scan <= '0;
      end
      if (cmd.finish) begin
        if (r_kind == REQ_DOWN) begin
          if (!tap_spoiled && tap_finger_total == finger_total && tap_number != 8'd0) begin
            gesture <= GST_PRE;
            taps <= (tap_number == 8'hFF) ? 8'hFF : tap_number + 8'd1;
          end
        end else if (r_kind == REQ_UP) begin
          lifting <= 1'b1;
          finger_total <= wr;
          if (wr == '0) begin
            lifting <= 1'b0;
            if (tap_spoiled) begin
              tap_number <= '0; tap_finger_total <= '0; spot_total <= '0;
              tap_spoiled <= 1'b0;
            end else begin
              gesture <= GST_TAP;
              taps <= (tap_number == 8'hFF) ? 8'hFF : tap_number + 8'd1;
              if (tap_number != 8'hFF) tap_number <= tap_number + 8'd1;
              prev_time <= r_time;
            end
          end
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        emit_i <= emit_i + 5'd1;
        out_data[1:0] <= (r_kind == REQ_DOWN) ? ACT_DOWN :
                         (r_kind == REQ_UP) ? ACT_UP :
                         (r_kind == REQ_MOVE) ? ACT_MOVE : ACT_NONE;
        out_data[33:2] <= r_id;
        out_data[49:34] <= r_x;
        out_data[65:50] <= r_y;
        out_data[81:66] <= r_dx;
        out_data[97:82] <= r_dy;
        out_data[99:98] <= gesture;
        out_data[107:100] <= taps;
        out_data[112:108] <= finger_total;
        out_data[128:113] <= (gesture != GST_NONE && emit_i < spot_total) ?
                             spot_x[emit_i[IdxW-1:0]] : '0;
        out_data[144:129] <= (gesture != GST_NONE && emit_i < spot_total) ?
                             spot_y[emit_i[IdxW-1:0]] : '0;
        out_data[151:145] <= '0;
        out_last <= (emit_i + 5'd1 == n_out);
      end
    end
  end

  always_comb begin
    n_out = 5'd1;
    if (gesture != GST_NONE && spot_total > 5'd1) n_out = spot_total;
  end
endmodule
`default_nettype wire

>>> hw/rtl/multi_finger_tap_recognizer.sv
`default_nettype none
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      req_type..event_time_ms in tdata
// m_axis    out        m_axis_tvalid/tready      action_type..gesture_y, tlast
// cfg       in         cfg_we                    cfg_index, cfg_data
// Down and no-event items pass through accept, decode, finish and emit.
// Motion adds a search over the entries and, when the finger is found, a
// distance check. Up adds a position copy and a compaction pass over the
// fingers held. A tap or pre-tap with several spots emits one result per spot.
// rst clears control state; table contents are undefined until written.
// A stalled output holds the emit state; the next item is taken after its
// last result.
`include "multi_finger_tap_recognizer_defines.svh"
module multi_finger_tap_recognizer
  import mftr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type, finger_id, pos_x, pos_y, delta_x, delta_y, event_time_ms
  input  wire logic [135:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // action_type, action_finger, action_x, action_y, motion_x, motion_y,
  // gesture_kind, taps_counted, fingers_down, gesture_x, gesture_y
  output logic [151:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  mftr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .sts(sts), .busy(busy), .cmd(cmd)
  );

  mftr_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(s_axis_tdata), .cmd(cmd), .sts(sts), .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid), .out_data(m_axis_tdata), .out_last(m_axis_tlast)
  );

  `MFTR_ASSERT(a_no_accept_busy, clk, rst, busy |-> !s_axis_tready, "accept while busy")
  `MFTR_ASSERT(a_load_idle, clk, rst, cmd.load |-> !busy, "load outside idle")
  `MFTR_ASSERT(a_emit_free, clk, rst, cmd.emit |-> !(m_axis_tvalid && !m_axis_tready), "overrun")
endmodule
`default_nettype wire

>>> dv/multi_finger_tap_recognizer_test.sv
`timescale 1ns / 100ps
`default_nettype none
module multi_finger_tap_recognizer_test;
  import mftr_pkg::*;

  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   SETTLE_CYCLES  = 60;

  typedef struct {
    req_t               kind;
    logic [31:0]        id;
    logic signed [15:0] px, py, dx, dy;
    logic [31:0]        stamp;
  } touch_t;

  typedef struct {
    act_t               act;
    logic [31:0]        finger;
    logic signed [15:0] ax, ay, mx, my;
    gst_t               gst;
    logic [7:0]         taps;
    logic [4:0]         fingers;
    logic signed [15:0] gx, gy;
    logic               last;
  } gesture_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tlast;

  multi_finger_tap_recognizer u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial forever #1 clk = ~clk;

  // tracker state held by the predictor
  logic [31:0] move_limit_sq;
  logic [31:0] tap_gap_ms;
  int          held_total;
  logic [31:0] held_id [16];
  int          held_nx [16], held_ny [16], held_sx [16], held_sy [16];
  int          tap_count, tap_fingers, spot_total;
  bit          spoiled, lifting;
  logic [31:0] last_tap_stamp;
  int          spot_x [16], spot_y [16];

  gesture_result_t expected_results [$];
  int  errors, items_sent, results_seen, taps_seen, pretaps_seen, spoils_seen;
  int  kind_seen [4];
  bit  quiet_phase;
  bit  sender_idle_on;
  int  hold_off_req;
  int  idle_cycles;
  logic [31:0] clock_ms;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic void clear_tap();
    tap_count = 0;
    tap_fingers = 0;
    spot_total = 0;
  endfunction

  function automatic void reset_tracker();
    move_limit_sq = 32'd400;
    tap_gap_ms = 32'd500;
    held_total = 0;
    clear_tap();
    spoiled = 0;
    lifting = 0;
    last_tap_stamp = '0;
  endfunction

  function automatic void predict_gestures(input touch_t e);
    act_t act;
    gst_t gst;
    int   taps, n, j;
    logic [31:0] gap;
    longint d2, ddx, ddy;
    gesture_result_t r;
    act = ACT_NONE;
    gst = GST_NONE;
    taps = 0;
    case (e.kind)
      REQ_DOWN: begin
        gap = e.stamp - last_tap_stamp;
        if (lifting) begin
          clear_tap();
          spoiled = 1;
        end else if (gap > tap_gap_ms) begin
          clear_tap();
        end
        if (held_total < 16) begin
          held_id[held_total] = e.id;
          held_nx[held_total] = e.px;
          held_ny[held_total] = e.py;
          held_sx[held_total] = e.px;
          held_sy[held_total] = e.py;
          held_total++;
        end
        act = ACT_DOWN;
        if (!spoiled && tap_fingers == held_total && tap_count >= 1) begin
          gst = GST_PRE;
          taps = tap_count < 255 ? tap_count + 1 : 255;
        end
      end
      REQ_MOVE: begin
        act = ACT_MOVE;
        for (int i = 0; i < held_total; i++) begin
          if (held_id[i] == e.id) begin
            ddx = longint'(e.px) - held_sx[i];
            ddy = longint'(e.py) - held_sy[i];
            d2 = ddx * ddx + ddy * ddy;
            held_nx[i] = e.px;
            held_ny[i] = e.py;
            if (d2 > longint'(move_limit_sq)) begin
              clear_tap();
              spoiled = 1;
              spoils_seen++;
            end
            break;
          end
        end
      end
      REQ_UP: begin
        act = ACT_UP;
        if (!lifting) begin
          if (held_total != tap_fingers) begin
            tap_count = 0;
            tap_fingers = held_total;
          end
          for (int i = 0; i < held_total; i++) begin
            spot_x[i] = held_nx[i];
            spot_y[i] = held_ny[i];
          end
          spot_total = held_total;
        end
        lifting = 1;
        j = 0;
        for (int i = 0; i < held_total; i++) begin
          if (held_id[i] != e.id) begin
            held_id[j] = held_id[i];
            held_nx[j] = held_nx[i];
            held_ny[j] = held_ny[i];
            held_sx[j] = held_sx[i];
            held_sy[j] = held_sy[i];
            j++;
          end
        end
        held_total = j;
        if (held_total == 0) begin
          if (spoiled) begin
            clear_tap();
            spoiled = 0;
          end else begin
            if (tap_count < 255) tap_count++;
            gst = GST_TAP;
            taps = tap_count;
            last_tap_stamp = e.stamp;
          end
          lifting = 0;
        end
      end
      default: act = ACT_NONE;
    endcase
    if (gst == GST_TAP) taps_seen++;
    if (gst == GST_PRE) pretaps_seen++;
    n = 1;
    if (gst != GST_NONE && spot_total > 1) n = spot_total;
    for (int i = 0; i < n; i++) begin
      r.act = act;
      r.finger = e.id;
      r.ax = e.px;
      r.ay = e.py;
      r.mx = e.dx;
      r.my = e.dy;
      r.gst = gst;
      r.taps = taps[7:0];
      r.fingers = held_total[4:0];
      r.gx = (gst != GST_NONE && i < spot_total) ? spot_x[i][15:0] : '0;
      r.gy = (gst != GST_NONE && i < spot_total) ? spot_y[i][15:0] : '0;
      r.last = (i == n - 1);
      expected_results.push_back(r);
    end
  endfunction

  task automatic send_touch(input touch_t e);
    if (sender_idle_on && !quiet_phase && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) @(negedge clk);
    s_axis_tdata = {6'b0, e.stamp, e.dy, e.dx, e.py, e.px, e.id, e.kind};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_gestures(e);
    items_sent++;
    kind_seen[e.kind]++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic touch_t make_touch(input req_t k, input logic [31:0] id,
                                        input int x, input int y);
    touch_t e;
    e.kind = k;
    e.id = id;
    e.px = x[15:0];
    e.py = y[15:0];
    e.dx = 16'($urandom());
    e.dy = 16'($urandom());
    clock_ms += $urandom_range(1, 40);
    e.stamp = clock_ms;
    return e;
  endfunction

  task automatic touch(input req_t k, input logic [31:0] id, input int x, input int y);
    send_touch(make_touch(k, id, x, y));
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    wait_drained();
    cfg_index = idx;
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MOVE_LIMIT) move_limit_sq = value;
    else tap_gap_ms = {16'b0, value[15:0]};
  endtask

  // result checker
  initial begin
    gesture_result_t exp_r;
    logic [151:0] d;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        d = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (d[1:0] !== exp_r.act) report_mismatch("action_type");
          if (d[33:2] !== exp_r.finger) report_mismatch("action_finger");
          if (d[49:34] !== exp_r.ax) report_mismatch("action_x");
          if (d[65:50] !== exp_r.ay) report_mismatch("action_y");
          if (d[81:66] !== exp_r.mx) report_mismatch("motion_x");
          if (d[97:82] !== exp_r.my) report_mismatch("motion_y");
          if (d[99:98] !== exp_r.gst) report_mismatch("gesture_kind");
          if (d[107:100] !== exp_r.taps) report_mismatch("taps_counted");
          if (d[112:108] !== exp_r.fingers) report_mismatch("fingers_down");
          if (d[128:113] !== exp_r.gx) report_mismatch("gesture_x");
          if (d[144:129] !== exp_r.gy) report_mismatch("gesture_y");
          if (m_axis_tlast !== exp_r.last) report_mismatch("tlast");
        end
      end
    end
  end

  // receiver: random stalls, requested hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        m_axis_tready = 1'b0;
        hold_off_req--;
      end else if (quiet_phase || $urandom_range(0, 4) != 0) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end
    end
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst ||
          (expected_results.size() == 0 && !s_axis_tvalid))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("multi_finger_tap_recognizer verification failed");
        $finish;
      end
    end
  end

  task automatic test_basic_taps();
    clock_ms = 32'hFFFF_FF00;
    touch(REQ_DOWN, 32'hFFFF_FFFF, 32767, -32768);
    touch(REQ_MOVE, 32'hFFFF_FFFF, 32767 - 3, -32768 + 4);
    touch(REQ_MOVE, 32'h0000_0007, 0, 0);
    touch(REQ_UP, 32'hFFFF_FFFF, 32767, -32768);
    touch(REQ_DOWN, 32'h0, -32768, 32767);
    touch(REQ_UP, 32'h0, -32768, 32767);
    touch(REQ_NONE, 32'hA5A5_A5A5, 1, 2);
    touch(REQ_DOWN, 32'h5, 10, 10);
    touch(REQ_DOWN, 32'h5, 20, 20);
    touch(REQ_UP, 32'h5, 0, 0);
    touch(REQ_DOWN, 32'h9, 100, 100);
    touch(REQ_MOVE, 32'h9, 200, -300);
    touch(REQ_UP, 32'h9, 200, -300);
    touch(REQ_UP, 32'h1234, 0, 0);
    clock_ms += 32'd10_000;
    touch(REQ_DOWN, 32'h3, 1, 1);
    touch(REQ_DOWN, 32'h4, 2, 2);
    touch(REQ_UP, 32'h3, 1, 1);
    touch(REQ_DOWN, 32'h6, 3, 3);
    touch(REQ_UP, 32'h4, 2, 2);
    touch(REQ_UP, 32'h6, 3, 3);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 17; i++) touch(REQ_DOWN, 32'h100 + i, i * 7 - 50, 50 - i * 3);
    for (int i = 0; i < 17; i++) touch(REQ_UP, 32'h100 + i, 0, 0);
    for (int i = 0; i < 16; i++) touch(REQ_DOWN, 32'h100 + i, i, -i);
  endtask

  task automatic tap_round(input int nf, input bit wild);
    logic [31:0] ids [16];
    int bx [16], by [16];
    int order [16];
    for (int i = 0; i < nf; i++) begin
      ids[i] = $urandom();
      bx[i] = $urandom_range(0, 65535) - 32768;
      by[i] = $urandom_range(0, 65535) - 32768;
      order[i] = i;
      touch(REQ_DOWN, ids[i], bx[i], by[i]);
    end
    for (int k = 0; k < $urandom_range(0, 2 * nf); k++) begin
      int f;
      f = $urandom_range(0, nf - 1);
      if (wild && $urandom_range(0, 5) == 0)
        touch(REQ_MOVE, ids[f], $urandom_range(0, 65535) - 32768, bx[f]);
      else
        touch(REQ_MOVE, ids[f], bx[f] + $urandom_range(0, 30) - 15,
              by[f] + $urandom_range(0, 30) - 15);
    end
    for (int i = nf - 1; i > 0; i--) begin
      int t, s;
      s = $urandom_range(0, i);
      t = order[i]; order[i] = order[s]; order[s] = t;
    end
    for (int i = 0; i < nf; i++) begin
      if (wild && $urandom_range(0, 7) == 0) begin
        touch(REQ_DOWN, $urandom(), $urandom_range(0, 100), 0);
        touch(REQ_UP, $urandom(), 0, 0);
      end
      touch(REQ_UP, ids[order[i]], bx[order[i]], by[order[i]]);
    end
  endtask

  task automatic test_random(input int budget);
    int start, nf;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        nf = $urandom_range(0, 15) == 0 ? $urandom_range(5, 16) : $urandom_range(1, 4);
        repeat ($urandom_range(1, 4)) tap_round(nf, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) clock_ms += $urandom_range(400, 70000);
        if ($urandom_range(0, 19) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
      end else begin
        touch(req_t'($urandom_range(0, 3)), $urandom(), $urandom_range(0, 65535) - 32768,
              $urandom_range(0, 65535) - 32768);
      end
    end
  endtask

  task automatic test_config_extremes();
    write_reg(REG_MOVE_LIMIT, 32'd0);
    write_reg(REG_TAP_GAP, 32'd0);
    test_random(40);
    write_reg(REG_MOVE_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_TAP_GAP, 32'hFFFF_FFFF);
    test_random(40);
    write_reg(REG_MOVE_LIMIT, $urandom_range(50, 5000));
    write_reg(REG_TAP_GAP, $urandom_range(20, 2000));
    test_random(40);
    write_reg(REG_MOVE_LIMIT, 32'd400);
    write_reg(REG_TAP_GAP, 32'd500);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_off_req = 400;
    for (int i = 0; i < 6; i++) touch(REQ_DOWN, 32'h200 + i, i, i);
    for (int i = 0; i < 6; i++) touch(REQ_UP, 32'h200 + i, i, i);
    wait_drained();
  endtask

  initial begin
    errors = 0; items_sent = 0; results_seen = 0;
    taps_seen = 0; pretaps_seen = 0; spoils_seen = 0;
    kind_seen = '{default: 0};
    quiet_phase = 0;
    sender_idle_on = 1;
    hold_off_req = 0;
    idle_cycles = 0;
    clock_ms = '0;
    reset_tracker();
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_basic_taps();
    test_table_full();
    test_backpressure();
    test_config_extremes();
    test_random(120);
    quiet_phase = 1;
    test_random(50);
    wait_drained();
    $display("covered %0d items (down %0d, up %0d, move %0d, none %0d), %0d results",
             items_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             results_seen);
    $display("taps %0d, pre-taps %0d, spoiling moves %0d, %0d mismatches",
             taps_seen, pretaps_seen, spoils_seen, errors);
    if (errors == 0)
      $display("multi_finger_tap_recognizer verification clean");
    else
      $display("multi_finger_tap_recognizer verification failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> multi_finger_tap_recognizer.f
+incdir+hw/rtl
hw/rtl/mftr_pkg.sv
hw/rtl/mftr_ctrl.sv
hw/rtl/mftr_datapath.sv
hw/rtl/multi_finger_tap_recognizer.sv
dv/multi_finger_tap_recognizer_test.sv
